FILE: src/assert_macros.svh
// Assertion macros shared by the smoother RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DSS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `DSS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: src/dss_pkg.sv
// Shared constants, codes and control/status types of the share smoother.
// No dependencies.
package dss_pkg;

  localparam int unsigned MAX_BINS_DEF = 64;

  localparam int unsigned SHARE_W    = 32;
  localparam int unsigned BIN_IDX_W  = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned WIN_W  = 7;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned PASS_W = 8;
  localparam int unsigned HALF_W = WIN_W - 1;
  localparam int unsigned HH_W   = 2 * HALF_W + 1;
  localparam int unsigned TRI_W  = 11;
  localparam int unsigned STEP_W = PCT_W + HALF_W;
  localparam int unsigned KEEP_W = 9;
  localparam int unsigned COEF_W = KEEP_W + TRI_W + 1;
  localparam int unsigned PROD_W = SHARE_W + 1 + COEF_W;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned DEN_W  = 18;
  localparam int unsigned REM_W  = DEN_W + SHARE_W;
  localparam int unsigned QCNT_W = $clog2(SHARE_W);

  localparam int unsigned PCT_SCALE  = 100;
  localparam int unsigned HALF_SCALE = 50;

  localparam logic [WIN_W-1:0]  WINDOW_RST = 7'd2;
  localparam logic [PASS_W-1:0] PASSES_RST = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW   = 3'd0,
    REG_FORWARD  = 3'd1,
    REG_BACKWARD = 3'd2,
    REG_PASSES   = 3'd3,
    REG_WRAP     = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SETUP1,
    ST_SETUP2,
    ST_PASS_CHK,
    ST_CLEAR,
    ST_SRC_RD,
    ST_KEEP_A,
    ST_KEEP_B,
    ST_NB_STEP,
    ST_BWD_A,
    ST_BWD_B,
    ST_FWD_A,
    ST_FWD_B,
    ST_SRC_NEXT,
    ST_SET_RD,
    ST_SET_CHK,
    ST_SET_DIV,
    ST_SET_NEXT,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } dss_state_e;

  typedef enum logic [1:0] {
    TGT_SELF,
    TGT_LO,
    TGT_HI
  } tgt_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_SAT,
    RES_QUOT
  } res_e;

  typedef struct packed {
    logic load_en;
    logic cnt_clr;
    logic setup1;
    logic setup2;
    logic idx_clr;
    logic idx_inc;
    logic pass_clr;
    logic pass_inc;
    logic cur_rd;
    logic nb_init;
    logic nb_step;
    logic nb_dec;
    logic acc_clr;
    logic add_a;
    logic add_b;
    logic acc_rd;
    logic div_start;
    logic cur_wr;
    tgt_e tgt;
    res_e res;
  } dss_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic h_zero;
    logic j_last;
    logic passes_left;
    logic acc_nonpos;
    logic acc_sat;
    logic div_done;
  } dss_sts_t;

endpackage

FILE: src/dss_intf.sv
// Valid/ready channel interfaces: input shares, smoothed results, config writes.
// Depends on dss_pkg for field widths.
interface dss_in_if import dss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SHARE_W-1:0] share_in;
  logic               last_in;

  modport source (output valid, share_in, last_in, input ready);
  modport sink   (input valid, share_in, last_in, output ready);
endinterface

interface dss_out_if import dss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SHARE_W-1:0]   share_out;
  logic [BIN_IDX_W-1:0] bin_index;
  logic                 last_out;

  modport source (output valid, share_out, bin_index, last_out, input ready);
  modport sink   (input valid, share_out, bin_index, last_out, output ready);
endinterface

interface dss_cfg_if import dss_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/dss_div.sv
// Restoring divider, one quotient bit per cycle, for the per-bin settle step.
// Depends on dss_pkg for widths.
module dss_div import dss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [REM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic               done_o,
  output logic [SHARE_W-1:0] quot_o
);

  logic [REM_W-1:0]   rem_q;
  logic [REM_W-1:0]   dsh_q;
  logic [SHARE_W-1:0] quot_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               busy_q;
  logic               done_q;
  logic               ge;

  assign ge = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + QCNT_W'(1);
      if (cnt_q == QCNT_W'(SHARE_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= REM_W'(den_i) << (SHARE_W - 1);
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[SHARE_W-2:0], ge};
      dsh_q  <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: src/dss_ctrl.sv
// Sequencer of the smoother: load, setup, passes (clear, scatter, settle), emit.
// Depends on dss_pkg for the state, command and status types.
module dss_ctrl import dss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  logic     out_ready_i,
  input  dss_sts_t sts_i,
  output dss_cmd_t cmd_o,
  output logic     in_ready_o,
  output logic     out_valid_o
);

  dss_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = ST_SETUP1;
      end
      ST_SETUP1:   state_d = ST_SETUP2;
      ST_SETUP2:   state_d = ST_PASS_CHK;
      ST_PASS_CHK: state_d = sts_i.passes_left ? ST_CLEAR : ST_EMIT_RD;
      ST_CLEAR: begin
        if (sts_i.idx_last) state_d = ST_SRC_RD;
      end
      ST_SRC_RD:   state_d = ST_KEEP_A;
      ST_KEEP_A:   state_d = ST_KEEP_B;
      ST_KEEP_B:   state_d = sts_i.h_zero ? ST_SRC_NEXT : ST_NB_STEP;
      ST_NB_STEP:  state_d = ST_BWD_A;
      ST_BWD_A:    state_d = ST_BWD_B;
      ST_BWD_B:    state_d = ST_FWD_A;
      ST_FWD_A:    state_d = ST_FWD_B;
      ST_FWD_B:    state_d = sts_i.j_last ? ST_SRC_NEXT : ST_NB_STEP;
      ST_SRC_NEXT: state_d = sts_i.idx_last ? ST_SET_RD : ST_SRC_RD;
      ST_SET_RD:   state_d = ST_SET_CHK;
      ST_SET_CHK: begin
        state_d = (sts_i.acc_nonpos || sts_i.acc_sat) ? ST_SET_NEXT : ST_SET_DIV;
      end
      ST_SET_DIV: begin
        if (sts_i.div_done) state_d = ST_SET_NEXT;
      end
      ST_SET_NEXT: state_d = sts_i.idx_last ? ST_PASS_CHK : ST_SET_RD;
      ST_EMIT_RD:  state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_ready_i) state_d = sts_i.idx_last ? ST_LOAD : ST_EMIT_RD;
      end
      default:     state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o    = 1'b1;
        cmd_o.load_en = in_valid_i;
      end
      ST_SETUP1: begin
        cmd_o.setup1   = 1'b1;
        cmd_o.pass_clr = 1'b1;
      end
      ST_SETUP2:   cmd_o.setup2 = 1'b1;
      ST_PASS_CHK: cmd_o.idx_clr = 1'b1;
      ST_CLEAR: begin
        cmd_o.acc_clr = 1'b1;
        cmd_o.idx_clr = sts_i.idx_last;
        cmd_o.idx_inc = !sts_i.idx_last;
      end
      ST_SRC_RD: begin
        cmd_o.cur_rd  = 1'b1;
        cmd_o.nb_init = 1'b1;
      end
      ST_KEEP_A: begin
        cmd_o.add_a = 1'b1;
        cmd_o.tgt   = TGT_SELF;
      end
      ST_KEEP_B:  cmd_o.add_b = 1'b1;
      ST_NB_STEP: cmd_o.nb_step = 1'b1;
      ST_BWD_A: begin
        cmd_o.add_a = 1'b1;
        cmd_o.tgt   = TGT_LO;
      end
      ST_BWD_B:   cmd_o.add_b = 1'b1;
      ST_FWD_A: begin
        cmd_o.add_a = 1'b1;
        cmd_o.tgt   = TGT_HI;
      end
      ST_FWD_B: begin
        cmd_o.add_b  = 1'b1;
        cmd_o.nb_dec = !sts_i.j_last;
      end
      ST_SRC_NEXT: begin
        cmd_o.idx_clr = sts_i.idx_last;
        cmd_o.idx_inc = !sts_i.idx_last;
      end
      ST_SET_RD: cmd_o.acc_rd = 1'b1;
      ST_SET_CHK: begin
        if (sts_i.acc_nonpos) begin
          cmd_o.cur_wr = 1'b1;
          cmd_o.res    = RES_ZERO;
        end else if (sts_i.acc_sat) begin
          cmd_o.cur_wr = 1'b1;
          cmd_o.res    = RES_SAT;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      ST_SET_DIV: begin
        cmd_o.cur_wr = sts_i.div_done;
        cmd_o.res    = RES_QUOT;
      end
      ST_SET_NEXT: begin
        cmd_o.pass_inc = sts_i.idx_last;
        cmd_o.idx_inc  = !sts_i.idx_last;
      end
      ST_EMIT_RD: cmd_o.cur_rd = 1'b1;
      ST_EMIT_WAIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.cnt_clr = sts_i.idx_last;
          cmd_o.idx_inc = !sts_i.idx_last;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: src/dss_dp.sv
// Datapath of the smoother: config registers, share and accumulator memories,
// multiply-accumulate, neighbor stepping and settle logic. Uses dss_div, dss_pkg.
module dss_dp import dss_pkg::*; #(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dss_cmd_t              cmd_i,
  output dss_sts_t              sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SHARE_W-1:0]    share_i,
  output logic [SHARE_W-1:0]    share_o,
  output logic [BIN_IDX_W-1:0]  bin_index_o,
  output logic                  last_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_BINS);
  localparam int unsigned CNT_W  = $clog2(MAX_BINS + 1);

  logic [WIN_W-1:0]  window_q;
  logic [PCT_W-1:0]  fwd_q;
  logic [PCT_W-1:0]  bwd_q;
  logic [PASS_W-1:0] passes_q;
  logic              wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RST;
      fwd_q    <= '0;
      bwd_q    <= '0;
      passes_q <= PASSES_RST;
      wrap_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW:   window_q <= cfg_data_i[WIN_W-1:0];
        REG_FORWARD:  fwd_q    <= cfg_data_i[PCT_W-1:0];
        REG_BACKWARD: bwd_q    <= cfg_data_i[PCT_W-1:0];
        REG_PASSES:   passes_q <= cfg_data_i[PASS_W-1:0];
        REG_WRAP:     wrap_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pass constants
  logic [HALF_W-1:0]        h;
  logic [HH_W-1:0]          hh;
  logic signed [KEEP_W-1:0] keep;
  logic [TRI_W-1:0]         tri_q;
  logic [STEP_W-1:0]        fh_q, bh_q;
  logic signed [COEF_W-1:0] kt_q;
  logic [DEN_W-1:0]         den_q, half_q;

  assign h    = window_q[WIN_W-1:1];
  assign hh   = HH_W'(h) * (HH_W'(h) + HH_W'(1));
  assign keep = $signed(KEEP_W'(PCT_SCALE) - KEEP_W'(fwd_q) - KEEP_W'(bwd_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup1) begin
      tri_q <= (h == '0) ? TRI_W'(1) : TRI_W'(hh >> 1);
      fh_q  <= STEP_W'(fwd_q) * STEP_W'(h);
      bh_q  <= STEP_W'(bwd_q) * STEP_W'(h);
    end
    if (cmd_i.setup2) begin
      kt_q   <= keep * $signed({1'b0, tri_q});
      den_q  <= DEN_W'(tri_q) * DEN_W'(PCT_SCALE);
      half_q <= DEN_W'(tri_q) * DEN_W'(HALF_SCALE);
    end
  end

  // counters and neighbor walk
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] idx_q;
  logic [PASS_W-1:0] pass_q;
  logic [ADDR_W-1:0] lo_q, hi_q, nm1;
  logic [HALF_W-1:0] j_q;
  logic [STEP_W-1:0] fj_q, bj_q;
  logic              load_we;

  assign nm1     = ADDR_W'(cnt_q - CNT_W'(1));
  assign load_we = cmd_i.load_en && (cnt_q < CNT_W'(MAX_BINS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      idx_q  <= '0;
      pass_q <= '0;
      lo_q   <= '0;
      hi_q   <= '0;
      j_q    <= '0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (load_we) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + ADDR_W'(1);
      end
      if (cmd_i.pass_clr) begin
        pass_q <= '0;
      end else if (cmd_i.pass_inc) begin
        pass_q <= pass_q + PASS_W'(1);
      end
      if (cmd_i.nb_init) begin
        lo_q <= idx_q;
        hi_q <= idx_q;
        j_q  <= h;
      end else begin
        if (cmd_i.nb_step) begin
          if (lo_q == '0) begin
            lo_q <= wrap_q ? nm1 : '0;
          end else begin
            lo_q <= lo_q - ADDR_W'(1);
          end
          if (hi_q >= nm1) begin
            hi_q <= wrap_q ? '0 : nm1;
          end else begin
            hi_q <= hi_q + ADDR_W'(1);
          end
        end
        if (cmd_i.nb_dec) begin
          j_q <= j_q - HALF_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_init) begin
      fj_q <= fh_q;
      bj_q <= bh_q;
    end else if (cmd_i.nb_dec) begin
      fj_q <= fj_q - STEP_W'(fwd_q);
      bj_q <= bj_q - STEP_W'(bwd_q);
    end
  end

  // share memory
  logic [SHARE_W-1:0] cur_mem [MAX_BINS];
  logic [SHARE_W-1:0] cur_rd_q;
  logic [SHARE_W-1:0] settle_res;
  logic [SHARE_W-1:0] quot;
  logic [ADDR_W-1:0]  cur_waddr;
  logic [SHARE_W-1:0] cur_wdata;

  assign cur_waddr = load_we ? ADDR_W'(cnt_q) : idx_q;
  assign cur_wdata = load_we ? share_i : settle_res;

  always_ff @(posedge clk_i) begin
    if (load_we || cmd_i.cur_wr) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    if (cmd_i.cur_rd) begin
      cur_rd_q <= cur_mem[idx_q];
    end
  end

  // scatter multiply-accumulate
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod_q;
  logic [ADDR_W-1:0]        tgt_addr, acc_addr_q, acc_raddr;
  logic signed [ACC_W-1:0]  acc_mem [MAX_BINS];
  logic signed [ACC_W-1:0]  acc_rd_q;

  always_comb begin
    case (cmd_i.tgt)
      TGT_SELF: begin
        coef     = kt_q;
        tgt_addr = idx_q;
      end
      TGT_LO: begin
        coef     = $signed(COEF_W'(bj_q));
        tgt_addr = lo_q;
      end
      TGT_HI: begin
        coef     = $signed(COEF_W'(fj_q));
        tgt_addr = hi_q;
      end
      default: begin
        coef     = '0;
        tgt_addr = idx_q;
      end
    endcase
  end

  assign acc_raddr = cmd_i.add_a ? tgt_addr : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add_a) begin
      prod_q     <= $signed({1'b0, cur_rd_q}) * coef;
      acc_addr_q <= tgt_addr;
    end
    if (cmd_i.add_a || cmd_i.acc_rd) begin
      acc_rd_q <= acc_mem[acc_raddr];
    end
    if (cmd_i.acc_clr) begin
      acc_mem[idx_q] <= '0;
    end else if (cmd_i.add_b) begin
      acc_mem[acc_addr_q] <= acc_rd_q + ACC_W'(prod_q);
    end
  end

  // settle: round half up, clamp at zero and at full scale
  logic [ACC_W-1:0] num;
  logic             acc_nonpos, acc_sat, div_done;

  assign num        = $unsigned(acc_rd_q) + ACC_W'(half_q);
  assign acc_nonpos = acc_rd_q[ACC_W-1] || (acc_rd_q == '0);
  assign acc_sat    = num >= ACC_W'({den_q, {SHARE_W{1'b0}}});

  dss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (REM_W'(num)),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    case (cmd_i.res)
      RES_ZERO: settle_res = '0;
      RES_SAT:  settle_res = '1;
      RES_QUOT: settle_res = quot;
      default:  settle_res = '0;
    endcase
  end

  assign sts_o.idx_last    = idx_q == nm1;
  assign sts_o.h_zero      = h == '0;
  assign sts_o.j_last      = j_q == HALF_W'(1);
  assign sts_o.passes_left = pass_q != passes_q;
  assign sts_o.acc_nonpos  = acc_nonpos;
  assign sts_o.acc_sat     = acc_sat;
  assign sts_o.div_done    = div_done;

  assign share_o     = cur_rd_q;
  assign bin_index_o = BIN_IDX_W'(idx_q);
  assign last_o      = sts_o.idx_last;

endmodule

FILE: src/diurnal_share_smoother.sv
// Diurnal share smoother, top level: sequencer, datapath and channel ports.
// Depends on dss_pkg, dss_intf, dss_ctrl, dss_dp and assert_macros.svh.
//
// Usage: shares (unsigned Q16.16) arrive one per transfer on in_i; the
// transfer with last_in set closes the set of n bins (at most MAX_BINS;
// extra shares are dropped). in_i stays ready throughout loading. After the
// closing transfer the block runs pass_count passes and then sends all n
// bins on out_o in order, with bin_index and last_out on the final bin.
// Each pass, with h = window_size / 2, is a clearing sweep of the accumulator
// memory, one read-modify-write of that memory for each of the 2*h+1
// contributions of a bin, and a settle of each bin by a one-bit-per-cycle
// divider unless the bin clamps to zero or saturates. Setup precedes the passes;
// in emission each bin is read from memory and then offered on out_o.
// in_i is not ready while a set is smoothed or emitted; a stall on out_o
// holds the current result until it is taken. Config writes on cfg_i are
// always taken and are meant for idle periods only.
// Reset (rst_ni low, asynchronous) empties the set and loads the default
// register values; memory contents are not cleared.
`include "assert_macros.svh"

module diurnal_share_smoother import dss_pkg::*; #(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dss_in_if.sink    in_i,
  dss_out_if.source out_o,
  dss_cfg_if.sink   cfg_i
);

  dss_cmd_t cmd;
  dss_sts_t sts;
  logic     in_ready;
  logic     out_valid;

  dss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_in),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid)
  );

  dss_dp #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .share_i     (in_i.share_in),
    .share_o     (out_o.share_out),
    .bin_index_o (out_o.bin_index),
    .last_o      (out_o.last_out)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;

  `DSS_ASSERT_NEVER(a_in_out_excl, clk_i, rst_ni, in_i.ready && out_o.valid, "load during emit")
  `DSS_ASSERT(a_last_to_load, clk_i, rst_ni, out_o.valid && out_o.ready && out_o.last_out |=> in_i.ready, "no reload after final bin")
  `DSS_ASSERT(a_div_range, clk_i, rst_ni, cmd.div_start |-> !sts.acc_nonpos && !sts.acc_sat, "divider started out of range")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for diurnal_share_smoother: feeds sets of Q16.16 bin shares, predicts the
// smoothed sets in exact fixed point and checks every bin as it leaves the block.
// Depends on dss_pkg and the channel interfaces in dss_intf.
module tb;
  import dss_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 300000;
  localparam int unsigned SET_COST_CAP    = 30000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 8;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [SHARE_W-1:0] share;
    logic               last;
  } share_item_t;

  typedef struct packed {
    logic [SHARE_W-1:0]   share;
    logic [BIN_IDX_W-1:0] idx;
    logic                 last;
  } bin_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  dss_in_if  in_ch ();
  dss_out_if out_ch ();
  dss_cfg_if cfg_ch ();

  diurnal_share_smoother uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  share_item_t share_q[$];
  bin_result_t smoothed_q[$];

  logic [SHARE_W-1:0] bin_share [MAX_BINS_DEF];
  int unsigned bins_held  = 0;
  int unsigned win_cfg    = WINDOW_RST;
  int unsigned fwd_cfg    = 0;
  int unsigned bwd_cfg    = 0;
  int unsigned pass_cfg   = PASSES_RST;
  bit          wrap_cfg   = 1'b0;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_done     = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatches     = 0;
  int unsigned shares_sent    = 0;
  int unsigned bins_checked   = 0;
  int unsigned sets_done      = 0;
  int unsigned settings_used  = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void smooth_pass(int unsigned n);
    int unsigned h;
    int unsigned lo;
    int unsigned hi;
    longint tri_sum;
    longint keep;
    longint s;
    longint q;
    longint div;
    longint acc [MAX_BINS_DEF];
    logic [SHARE_W-1:0] prev [MAX_BINS_DEF];
    h = win_cfg >> 1;
    tri_sum = (h == 0) ? 64'sd1 : longint'(h * (h + 1) / 2);
    keep = longint'(PCT_SCALE) - longint'(fwd_cfg) - longint'(bwd_cfg);
    div = longint'(PCT_SCALE) * tri_sum;
    prev = bin_share;
    foreach (acc[i]) acc[i] = 0;
    for (int unsigned i = 0; i < n; i++) begin
      s = longint'(prev[i]);
      acc[i] += s * keep * tri_sum;
      lo = i;
      hi = i;
      for (int unsigned j = h; j > 0; j--) begin
        if (lo == 0) lo = wrap_cfg ? n - 1 : 0;
        else lo--;
        if (hi >= n - 1) hi = wrap_cfg ? 0 : n - 1;
        else hi++;
        acc[lo] += s * longint'(bwd_cfg) * longint'(j);
        acc[hi] += s * longint'(fwd_cfg) * longint'(j);
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (acc[i] <= 0) begin
        bin_share[i] = '0;
      end else begin
        q = (acc[i] + div / 2) / div;
        if (q > longint'(32'hFFFF_FFFF)) bin_share[i] = '1;
        else bin_share[i] = q[SHARE_W-1:0];
      end
    end
  endfunction

  function automatic void take_share(logic [SHARE_W-1:0] share, logic last);
    bin_result_t res;
    if (bins_held < MAX_BINS_DEF) begin
      bin_share[bins_held] = share;
      bins_held++;
    end
    if (last) begin
      for (int unsigned p = 0; p < pass_cfg; p++) smooth_pass(bins_held);
      for (int unsigned k = 0; k < bins_held; k++) begin
        res.share = bin_share[k];
        res.idx   = BIN_IDX_W'(k);
        res.last  = (k + 1 == bins_held);
        smoothed_q.push_back(res);
      end
      bins_held = 0;
      sets_done++;
    end
  endfunction

  function automatic void check_bin(logic [SHARE_W-1:0] share, logic [BIN_IDX_W-1:0] idx,
                                    logic last);
    bin_result_t want;
    if (smoothed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected bin idx %0d share %h last %b", $time, idx, share, last);
    end else begin
      want = smoothed_q.pop_front();
      bins_checked++;
      if (share !== want.share || idx !== want.idx || last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: expected idx %0d share %h last %b, got idx %0d share %h last %b",
                   $time, want.idx, want.share, want.last, idx, share, last);
      end
    end
  endfunction

  // driver: hold the offered share until its transfer, then advance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid    <= 1'b0;
      in_ch.share_in <= '0;
      in_ch.last_in  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        take_share(in_ch.share_in, in_ch.last_in);
        shares_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (share_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid    <= 1'b1;
          in_ch.share_in <= share_q[0].share;
          in_ch.last_in  <= share_q[0].last;
          void'(share_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each transfer, stall at random or for a long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        check_bin(out_ch.share_out, out_ch.bin_index, out_ch.last_out);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_done != holds_asked && out_ch.valid) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_WINDOW:   win_cfg  = value & 'h7F;
      REG_FORWARD:  fwd_cfg  = value & 'h7F;
      REG_BACKWARD: bwd_cfg  = value & 'h7F;
      REG_PASSES:   pass_cfg = value & 'hFF;
      REG_WRAP:     wrap_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(int unsigned window, int unsigned fwd, int unsigned bwd,
                               int unsigned passes, int unsigned wrap);
    write_reg(REG_WINDOW, window);
    write_reg(REG_FORWARD, fwd);
    write_reg(REG_BACKWARD, bwd);
    write_reg(REG_PASSES, passes);
    write_reg(REG_WRAP, wrap);
    settings_used++;
  endtask

  task automatic wait_drain();
    do @(negedge clk_i);
    while (share_q.size() != 0 || in_ch.valid || smoothed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic void queue_share(logic [SHARE_W-1:0] share, logic last);
    share_item_t it;
    it.share = share;
    it.last  = last;
    share_q.push_back(it);
  endfunction

  function automatic logic [SHARE_W-1:0] pick_share();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(32'h0001_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic longint set_cost(int unsigned n);
    return longint'(pass_cfg) * (1 + n * (41 + 5 * (win_cfg >> 1))) + 2 + 2 * n;
  endfunction

  function automatic void queue_random_set(int unsigned len);
    for (int unsigned k = 0; k < len; k++) queue_share(pick_share(), k == len - 1);
  endfunction

  task automatic random_phase(bit with_overflow);
    int unsigned window;
    int unsigned fwd;
    int unsigned bwd;
    int unsigned passes;
    int unsigned len;
    int unsigned used;
    case ($urandom_range(9))
      0: begin
        passes = 0;
        window = $urandom_range(127);
      end
      1: begin
        passes = 255;
        window = $urandom_range(3);
      end
      2: begin
        passes = $urandom_range(40, 9);
        window = $urandom_range(7);
      end
      default: begin
        passes = $urandom_range(4, 1);
        window = $urandom_range(127);
      end
    endcase
    fwd = $urandom_range(100);
    bwd = ($urandom_range(4) == 0) ? $urandom_range(100) : $urandom_range(100 - fwd);
    if (with_overflow) begin
      passes = 1;
      window = 4;
    end
    apply_setting(window, fwd, bwd, passes, $urandom_range(1));
    used = 0;
    if (with_overflow) begin
      len = MAX_BINS_DEF + $urandom_range(4, 1);
      queue_random_set(len);
      used = len;
    end
    while (used < ITEMS_PER_PHASE) begin
      len = ($urandom_range(5) == 0) ? $urandom_range(MAX_BINS_DEF, 1) : $urandom_range(12, 1);
      while (len > 1 && set_cost(len) > SET_COST_CAP) len--;
      queue_random_set(len);
      used += len;
    end
    wait_drain();
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WINDOW;
    cfg_ch.data  = '0;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 31;
    recv_idle_pct = 47;

    queue_share(32'h0000_0000, 1'b0);
    queue_share(32'hFFFF_FFFF, 1'b0);
    queue_share(32'hAAAA_AAAA, 1'b0);
    queue_share(32'h5555_5555, 1'b1);
    wait_drain();
    queue_share(32'h1234_5678, 1'b1);
    wait_drain();

    // zero half window: moved parts are dropped
    apply_setting(1, 30, 20, 2, 0);
    queue_share(32'h0001_0000, 1'b0);
    queue_share(32'hFFFF_FFFF, 1'b0);
    queue_share(32'h8000_0000, 1'b1);
    wait_drain();

    // full window, percents over a hundred, wrap far past the set length
    apply_setting(127, 100, 100, 1, 1);
    queue_share(32'h0003_0000, 1'b0);
    queue_share(32'hFFFF_FFFF, 1'b0);
    queue_share(32'h0000_0001, 1'b1);
    wait_drain();

    apply_setting(20, 25, 15, 3, 1);
    queue_share(32'h0100_0000, 1'b0);
    queue_share(32'h0000_0000, 1'b0);
    queue_share(32'h7FFF_FFFF, 1'b1);
    wait_drain();

    // clamped ends pile up on the last bin and saturate
    apply_setting(4, 100, 0, 1, 0);
    queue_share(32'hFFFF_FFFF, 1'b0);
    queue_share(32'hFFFF_FFFF, 1'b0);
    queue_share(32'hFFFF_FFFF, 1'b1);
    wait_drain();

    apply_setting(9, 10, 60, 0, 0);
    queue_share(32'hDEAD_BEEF, 1'b0);
    queue_share(32'h0000_0001, 1'b1);
    wait_drain();

    apply_setting(2, 50, 50, 255, 1);
    queue_share(32'hFFFF_FFFF, 1'b0);
    queue_share(32'h0000_8000, 1'b1);
    wait_drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 31 : (mode == 1) ? 47 : 0;
      recv_idle_pct = (mode == 0) ? 47 : (mode == 1) ? 31 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        if (mode == 2 && ph == 0) holds_asked++;
        random_phase(mode == 0 && ph == 0);
      end
    end

    $display("%0d shares in %0d sets under %0d register settings, %0d smoothed bins checked",
             shares_sent, sets_done, settings_used, bins_checked);
    $display("wrap and clamp, zero to full windows, set overflow, %0d-cycle stall, %0d mismatches",
             HOLD_CYCLES, mismatches);
    if (mismatches == 0 && smoothed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
